// ----- hw/rtl/sjsr_pkg.sv -----
// Package for the servo joint slew ramp: field widths, register indexes,
// divide-by-180 reciprocal constants and the pipeline load struct.
// No dependencies.
package sjsr_pkg;

	localparam int NUM_JOINTS = 3;
	localparam int ANGLE_W    = 10;
	localparam int STEP_W     = 8;
	localparam int CFG_W      = 12;
	localparam int DIST_W     = ANGLE_W + 1;

	// input tdata: target_coxa, target_femur, target_tibia, step_size
	localparam int IN_BITS    = NUM_JOINTS * ANGLE_W + STEP_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_COXA_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COXA_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEMUR_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FEMUR_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIBIA_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIBIA_MAX = 3'd5;

	localparam logic [CFG_W-1:0] PULSE_MIN_RST = 12'd150;
	localparam logic [CFG_W-1:0] PULSE_MAX_RST = 12'd600;

	// opcodes
	localparam logic OP_JUMP = 1'b0;
	localparam logic OP_RAMP = 1'b1;

	// scaling datapath
	localparam int SPAN_W = CFG_W + 1;            // max - min, signed
	localparam int PROD_W = ANGLE_W + SPAN_W;     // angle * span, signed
	localparam int MAG_W  = PROD_W - 1;           // |product|
	localparam int QIN_W  = MAG_W - 2;            // |product| / 4
	localparam int RECIP_W = 22;
	localparam int RECIP_SHIFT = 27;
	// ceil(2^27 / 45): exact floor(n / 45) for n < 2^20
	localparam logic [RECIP_W-1:0] RECIP_45 = 22'd2982617;
	localparam int QPROD_W = QIN_W + RECIP_W;
	localparam int QUO_W   = QPROD_W - RECIP_SHIFT;
	localparam int SUM_W   = 18;

	typedef struct packed {
		logic ld1;   // item accepted into the lanes
		logic ld2;
		logic ld3;
		logic ld4;   // output register loads
	} stage_ld_t;

endpackage

// ----- hw/rtl/sjsr_lane.sv -----
// One joint lane: holds the current angle and steps it toward the target.
// Depends on sjsr_pkg.
module sjsr_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sjsr_pkg::stage_ld_t                 ld,
	input  logic                                opcode,
	input  logic signed [sjsr_pkg::ANGLE_W-1:0] target,
	input  logic [sjsr_pkg::STEP_W-1:0]         step_size,
	output logic signed [sjsr_pkg::ANGLE_W-1:0] angle_s1,
	output logic                                write_s1
);

	logic signed [sjsr_pkg::ANGLE_W-1:0] angle_q;
	logic signed [sjsr_pkg::DIST_W-1:0]  cur_x, tgt_x, diff, step_x, nxt_x;
	logic [sjsr_pkg::DIST_W-1:0]         delta_mag;
	logic                                differ;

	always_comb begin
		cur_x  = sjsr_pkg::DIST_W'(angle_q);
		tgt_x  = sjsr_pkg::DIST_W'(target);
		step_x = $signed({{(sjsr_pkg::DIST_W-sjsr_pkg::STEP_W){1'b0}}, step_size});
		diff   = tgt_x - cur_x;
		delta_mag = diff[sjsr_pkg::DIST_W-1] ? sjsr_pkg::DIST_W'(-diff)
		                                     : sjsr_pkg::DIST_W'(diff);
		differ = (angle_q != target);
		priority if (!differ) begin
			nxt_x = cur_x;
		end else if (opcode == sjsr_pkg::OP_JUMP || delta_mag < $unsigned(step_x)) begin
			nxt_x = tgt_x;
		end else if (!diff[sjsr_pkg::DIST_W-1]) begin
			nxt_x = cur_x + step_x;
		end else begin
			nxt_x = cur_x - step_x;
		end
	end

	// ramped angle stays between old value and target, so it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '1;
		end else if (ld.ld1) begin
			angle_q <= nxt_x[sjsr_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld1) begin
			angle_s1 <= nxt_x[sjsr_pkg::ANGLE_W-1:0];
			write_s1 <= differ;
		end
	end

endmodule

// ----- hw/rtl/sjsr_scale.sv -----
// Pulse scaling for one joint: angle*(max-min)/180 + min, saturated.
// Three stages (multiply, reciprocal divide, add and clamp). Depends on sjsr_pkg.
module sjsr_scale #(
	parameter int PULSE_BITS = 12
) (
	input  logic                                clk,
	input  sjsr_pkg::stage_ld_t                 ld,
	input  logic signed [sjsr_pkg::ANGLE_W-1:0] angle_s1,
	input  logic                                write_s1,
	input  logic [sjsr_pkg::CFG_W-1:0]          pulse_min,
	input  logic [sjsr_pkg::CFG_W-1:0]          pulse_max,
	output logic [PULSE_BITS-1:0]               pulse_s4,
	output logic                                write_s4
);

	localparam logic signed [sjsr_pkg::SUM_W-1:0] PULSE_TOP =
		sjsr_pkg::SUM_W'((1 << PULSE_BITS) - 1);

	logic signed [sjsr_pkg::PROD_W-1:0]  angle_x, span_x, prod_c, prod_s2;
	logic                                write_s2, write_s3, neg_s3;
	logic [sjsr_pkg::MAG_W-1:0]          mag;
	logic [sjsr_pkg::QPROD_W-1:0]        qprod;
	logic [sjsr_pkg::QUO_W-1:0]          quo_s3;
	logic signed [sjsr_pkg::SUM_W-1:0]   quo_x, min_x, sum, sat;

	// stage 2: signed product
	always_comb begin
		angle_x = sjsr_pkg::PROD_W'(angle_s1);
		span_x  = sjsr_pkg::PROD_W'($signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min}));
		prod_c  = angle_x * span_x;
	end

	always_ff @(posedge clk) begin
		if (ld.ld2) begin
			prod_s2  <= prod_c;
			write_s2 <= write_s1;
		end
	end

	// stage 3: |p|/180 = (|p|>>2)/45 by reciprocal, sign kept aside
	always_comb begin
		mag   = prod_s2[sjsr_pkg::PROD_W-1] ? sjsr_pkg::MAG_W'(-prod_s2)
		                                    : sjsr_pkg::MAG_W'(prod_s2);
		qprod = sjsr_pkg::QPROD_W'(mag[sjsr_pkg::MAG_W-1:2])
		        * sjsr_pkg::QPROD_W'(sjsr_pkg::RECIP_45);
	end

	always_ff @(posedge clk) begin
		if (ld.ld3) begin
			quo_s3   <= qprod[sjsr_pkg::QPROD_W-1:sjsr_pkg::RECIP_SHIFT];
			neg_s3   <= prod_s2[sjsr_pkg::PROD_W-1];
			write_s3 <= write_s2;
		end
	end

	// stage 4: restore sign (truncation toward zero), add min, clamp
	always_comb begin
		quo_x = $signed(sjsr_pkg::SUM_W'(quo_s3));
		if (neg_s3) begin
			quo_x = -quo_x;
		end
		min_x = $signed(sjsr_pkg::SUM_W'(pulse_min));
		sum   = quo_x + min_x;
		priority if (sum < 0) begin
			sat = '0;
		end else if (sum > PULSE_TOP) begin
			sat = PULSE_TOP;
		end else begin
			sat = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld4) begin
			pulse_s4 <= write_s3 ? sat[PULSE_BITS-1:0] : '0;
			write_s4 <= write_s3;
		end
	end

endmodule

// ----- hw/rtl/servo_joint_slew_ramp_top.sv -----
// Throughput: 1 item per cycle while m_tready does not stall the result stream.
// The angle update loop (compare, step) closes through one angle register per lane; scaling
// runs in three further stages (multiply, reciprocal divide, add/clamp).
// Reset (arst_n, async): angles -1, pulse ranges 150..600, pipeline empty.
// s_tready drops only while the output register holds an untaken result and
// every stage behind it is full.
module servo_joint_slew_ramp_top #(
	parameter int PULSE_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input items
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tdata: target_coxa[9:0], target_femur[19:10], target_tibia[29:20],
	//        step_size[37:30], zero fill
	input  logic [sjsr_pkg::IN_TDATA_W-1:0]      s_tdata,
	// tuser: opcode[0]
	input  logic [0:0]                           s_tuser,
	// result items
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tdata: pulse_coxa, pulse_femur, pulse_tibia (PULSE_BITS each),
	//        write_coxa, write_femur, write_tibia, stopped, zero fill
	output logic [((3*PULSE_BITS+4+7)/8)*8-1:0]  m_tdata,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sjsr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sjsr_pkg::CFG_W-1:0]           cfg_data
);

	localparam int NJ = sjsr_pkg::NUM_JOINTS;
	localparam int AW = sjsr_pkg::ANGLE_W;
	localparam int FLAG_LSB = NJ * PULSE_BITS;

	// pulse range registers, one pair per joint
	logic [sjsr_pkg::CFG_W-1:0] pmin_q [NJ];
	logic [sjsr_pkg::CFG_W-1:0] pmax_q [NJ];

	// pipeline occupancy
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready1, ready2, ready3, ready4;
	sjsr_pkg::stage_ld_t ld;

	logic signed [AW-1:0]  angle_s1 [NJ];
	logic                  write_s1 [NJ];
	logic [PULSE_BITS-1:0] pulse_s4 [NJ];
	logic                  write_s4 [NJ];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NJ; j++) begin
				pmin_q[j] <= sjsr_pkg::PULSE_MIN_RST;
				pmax_q[j] <= sjsr_pkg::PULSE_MAX_RST;
			end
		end else if (cfg_valid) begin
			// indexes past the last register are dropped
			unique case (cfg_index)
				sjsr_pkg::REG_COXA_MIN:  pmin_q[0] <= cfg_data;
				sjsr_pkg::REG_COXA_MAX:  pmax_q[0] <= cfg_data;
				sjsr_pkg::REG_FEMUR_MIN: pmin_q[1] <= cfg_data;
				sjsr_pkg::REG_FEMUR_MAX: pmax_q[1] <= cfg_data;
				sjsr_pkg::REG_TIBIA_MIN: pmin_q[2] <= cfg_data;
				sjsr_pkg::REG_TIBIA_MAX: pmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// each stage loads when it is empty or its item moves on this edge
	always_comb begin
		ready4 = !valid_s4 || m_tready;
		ready3 = !valid_s3 || ready4;
		ready2 = !valid_s2 || ready3;
		ready1 = !valid_s1 || ready2;
		ld.ld1 = s_tvalid && ready1;
		ld.ld2 = valid_s1 && ready2;
		ld.ld3 = valid_s2 && ready3;
		ld.ld4 = valid_s3 && ready4;
	end

	assign s_tready = ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ld.ld1)      valid_s1 <= 1'b1;
			else if (ld.ld2) valid_s1 <= 1'b0;
			if (ld.ld2)      valid_s2 <= 1'b1;
			else if (ld.ld3) valid_s2 <= 1'b0;
			if (ld.ld3)      valid_s3 <= 1'b1;
			else if (ld.ld4) valid_s3 <= 1'b0;
			if (ld.ld4)      valid_s4 <= 1'b1;
			else if (m_tready) valid_s4 <= 1'b0;
		end
	end

	// one lane per joint: angle update, then pulse scaling
	for (genvar j = 0; j < NJ; j++) begin : g_joint
		sjsr_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ld        (ld),
			.opcode    (s_tuser[0]),
			.target    ($signed(s_tdata[j*AW +: AW])),
			.step_size (s_tdata[NJ*AW +: sjsr_pkg::STEP_W]),
			.angle_s1  (angle_s1[j]),
			.write_s1  (write_s1[j])
		);

		sjsr_scale #(
			.PULSE_BITS (PULSE_BITS)
		) u_scale (
			.clk       (clk),
			.ld        (ld),
			.angle_s1  (angle_s1[j]),
			.write_s1  (write_s1[j]),
			.pulse_min (pmin_q[j]),
			.pulse_max (pmax_q[j]),
			.pulse_s4  (pulse_s4[j]),
			.write_s4  (write_s4[j])
		);
	end

	// merge: pack lane results, stopped when no joint moved
	assign m_tvalid = valid_s4;

	always_comb begin
		m_tdata = '0;
		for (int j = 0; j < NJ; j++) begin
			m_tdata[j*PULSE_BITS +: PULSE_BITS] = pulse_s4[j];
			m_tdata[FLAG_LSB + j]               = write_s4[j];
		end
		m_tdata[FLAG_LSB + NJ] = !(write_s4[0] || write_s4[1] || write_s4[2]);
	end

endmodule

// ----- hw/rtl/sjsr_checker.sv -----
// Port-level checks for servo_joint_slew_ramp_top, bound to every instance.
// Depends on sjsr_pkg and the top level's port list.
module sjsr_checker #(
	parameter int PULSE_BITS = 12
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [sjsr_pkg::IN_TDATA_W-1:0]      s_tdata,
	input logic [0:0]                           s_tuser,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((3*PULSE_BITS+4+7)/8)*8-1:0]  m_tdata,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [sjsr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [sjsr_pkg::CFG_W-1:0]           cfg_data
);

	localparam int FL = 3 * PULSE_BITS;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// stopped exactly when no write flag
	a_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[FL+3] == !(m_tdata[FL] || m_tdata[FL+1] || m_tdata[FL+2])))
		else $error("stopped flag disagrees with write flags");

	// joints that did not move report a zero pulse
	a_idle_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(m_tdata[FL]   || m_tdata[PULSE_BITS-1:0] == '0) &&
			(m_tdata[FL+1] || m_tdata[2*PULSE_BITS-1:PULSE_BITS] == '0) &&
			(m_tdata[FL+2] || m_tdata[3*PULSE_BITS-1:2*PULSE_BITS] == '0))
		else $error("pulse given for a joint without write flag");

	// a draining sink never blocks the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

endmodule

bind servo_joint_slew_ramp_top sjsr_checker #(.PULSE_BITS(PULSE_BITS)) u_sjsr_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for servo_joint_slew_ramp_top: jump/ramp moves, pulse
// scaling, saturation and register writes, with random stalls on both streams.
// Depends on sjsr_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
	import sjsr_pkg::*;

	localparam int PULSE_BITS  = 12;
	localparam int OUT_TDATA_W = ((3*PULSE_BITS+4+7)/8)*8;
	localparam longint PULSE_TOP = (longint'(1) << PULSE_BITS) - 1;
	localparam int DRAIN_PAD   = 10;        // margin over the pipeline depth
	localparam int RUN_LIMIT_NS = 10_000_000;

	// indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] MIN_REG [3] = '{REG_COXA_MIN, REG_FEMUR_MIN, REG_TIBIA_MIN};
	localparam logic [CFG_IDX_W-1:0] MAX_REG [3] = '{REG_COXA_MAX, REG_FEMUR_MAX, REG_TIBIA_MAX};

	typedef struct packed {
		logic                     op;
		logic [2:0][ANGLE_W-1:0]  tgt;   // [0] coxa, [1] femur, [2] tibia
		logic [STEP_W-1:0]        step;
	} slew_cmd_t;

	typedef struct packed {
		logic [2:0][PULSE_BITS-1:0] pulse;
		logic [2:0]                 wr;
		logic                       stopped;
	} servo_upd_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata   = '0;   // tgt_coxa, tgt_femur, tgt_tibia, step, fill
	logic [0:0]              s_tuser   = '0;   // opcode
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;          // 3 pulses, 3 write flags, stopped
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data  = '0;

	servo_joint_slew_ramp_top #(
		.PULSE_BITS(PULSE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// shadow of the block: joint angles and pulse ranges
	int              joint_ang [3];
	logic [CFG_W-1:0] range_lo [3];
	logic [CFG_W-1:0] range_hi [3];

	servo_upd_t due_updates[$];   // predicted result items, oldest first
	string joint_tag [3] = '{"coxa", "femur", "tibia"};

	int  err_count    = 0;
	int  items_sent   = 0;
	int  ramp_items   = 0;
	int  jump_items   = 0;
	int  updates_seen = 0;
	int  reg_writes   = 0;
	int  range_sets   = 0;
	int  quiet_waits  = 0;
	bit  tx_idle_en   = 1'b1;
	bit  rx_idle_en   = 1'b1;
	int  rx_hold      = 0;

	// angle*(max-min)/180 + min, truncated toward zero, then clamped
	function automatic logic [PULSE_BITS-1:0] pulse_scale(int ang, logic [CFG_W-1:0] lo,
			logic [CFG_W-1:0] hi);
		longint p;
		p = (longint'(ang) * (longint'(hi) - longint'(lo))) / 180 + longint'(lo);
		if (p < 0)
			p = 0;
		if (p > PULSE_TOP)
			p = PULSE_TOP;
		return p[PULSE_BITS-1:0];
	endfunction

	// moves the shadow joints for one item and returns the result it must give
	function automatic servo_upd_t advance_joints(slew_cmd_t c);
		servo_upd_t r;
		int cur;
		int tgt;
		int delta;
		int st;
		r = '0;
		r.stopped = 1'b1;
		st = int'(c.step);
		for (int j = 0; j < 3; j++) begin
			tgt = $signed(c.tgt[j]);
			cur = joint_ang[j];
			if (cur != tgt) begin
				delta = (cur > tgt) ? cur - tgt : tgt - cur;
				r.stopped = 1'b0;
				if (c.op == OP_JUMP || delta < st)
					cur = tgt;
				else if (cur < tgt)
					cur += st;
				else
					cur -= st;
				joint_ang[j] = cur;
				r.pulse[j] = pulse_scale(cur, range_lo[j], range_hi[j]);
				r.wr[j] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic bit joints_settled(slew_cmd_t c);
		for (int j = 0; j < 3; j++)
			if (joint_ang[j] != $signed(c.tgt[j]))
				return 1'b0;
		return 1'b1;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [ANGLE_W-1:0] pick_angle();
		int a;
		case ($urandom_range(0, 19))
			0:       a = -180;
			1:       a = 360;
			2:       a = 0;
			3:       a = 180;
			4:       a = -1;
			default: a = int'($urandom_range(0, 540)) - 180;
		endcase
		return a[ANGLE_W-1:0];
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 75)
			return STEP_W'($urandom_range(1, 40));
		return STEP_W'($urandom_range(41, 255));
	endfunction

	function automatic logic [CFG_W-1:0] pick_pulse();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return CFG_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// result side: random stalls on m_tready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold  <= 0;
		end else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
			m_tready <= 1'b0;
			rx_hold  <= pick_gap() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker: every accepted item against the oldest prediction
	always @(posedge clk) begin
		servo_upd_t want;
		servo_upd_t got;
		if (arst_n && m_tvalid && m_tready) begin
			for (int j = 0; j < 3; j++) begin
				got.pulse[j] = m_tdata[j*PULSE_BITS +: PULSE_BITS];
				got.wr[j]    = m_tdata[3*PULSE_BITS + j];
			end
			got.stopped = m_tdata[3*PULSE_BITS + 3];
			if (due_updates.size() == 0) begin
				err_count++;
				$display("%0t: result item with nothing expected, tdata %h", $time, m_tdata);
			end else begin
				want = due_updates.pop_front();
				updates_seen++;
				for (int j = 0; j < 3; j++) begin
					if (got.pulse[j] !== want.pulse[j]) begin
						err_count++;
						$display("%0t: pulse_%s mismatch: expected %0d, got %0d", $time,
							joint_tag[j], want.pulse[j], got.pulse[j]);
					end
					if (got.wr[j] !== want.wr[j]) begin
						err_count++;
						$display("%0t: write_%s mismatch: expected %0d, got %0d", $time,
							joint_tag[j], want.wr[j], got.wr[j]);
					end
				end
				if (got.stopped !== want.stopped) begin
					err_count++;
					$display("%0t: stopped mismatch: expected %0d, got %0d", $time,
						want.stopped, got.stopped);
				end
			end
		end
	end

	// one input item; valid stays up if the next one follows without a gap
	task automatic send_item(slew_cmd_t c);
		int gap;
		gap = (tx_idle_en && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.op;
		s_tdata  <= IN_TDATA_W'({c.step, c.tgt});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		due_updates.push_back(advance_joints(c));
		items_sent++;
		if (c.op == OP_RAMP)
			ramp_items++;
		else
			jump_items++;
	endtask

	task automatic send_move(logic op, int tc, int tf, int tt, int st);
		slew_cmd_t c;
		c.op = op;
		c.tgt[0] = tc[ANGLE_W-1:0];
		c.tgt[1] = tf[ANGLE_W-1:0];
		c.tgt[2] = tt[ANGLE_W-1:0];
		c.step = st[STEP_W-1:0];
		send_item(c);
	endtask

	// stop sending, let every expected item come back, then let the pipe empty
	task automatic wait_until_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_updates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
		quiet_waits++;
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_COXA_MIN:  range_lo[0] = val;
			REG_COXA_MAX:  range_hi[0] = val;
			REG_FEMUR_MIN: range_lo[1] = val;
			REG_FEMUR_MAX: range_hi[1] = val;
			REG_TIBIA_MIN: range_lo[2] = val;
			REG_TIBIA_MAX: range_hi[2] = val;
			default:       ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_range(int lo_c, int hi_c, int lo_f, int hi_f, int lo_t, int hi_t);
		wait_until_quiet();
		cfg_write(MIN_REG[0], lo_c[CFG_W-1:0]);
		cfg_write(MAX_REG[0], hi_c[CFG_W-1:0]);
		cfg_write(MIN_REG[1], lo_f[CFG_W-1:0]);
		cfg_write(MAX_REG[1], hi_f[CFG_W-1:0]);
		cfg_write(MIN_REG[2], lo_t[CFG_W-1:0]);
		cfg_write(MAX_REG[2], hi_t[CFG_W-1:0]);
		range_sets++;
	endtask

	// well-formed ramp toward fixed targets until settled, sometimes cut short
	task automatic ramp_episode();
		slew_cmd_t c;
		int n;
		int lim;
		c.op = OP_RAMP;
		for (int j = 0; j < 3; j++)
			c.tgt[j] = ($urandom_range(0, 4) == 0) ? joint_ang[j][ANGLE_W-1:0] : pick_angle();
		c.step = pick_step();
		lim = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 40;
		if (c.step == 0)
			lim = 3;
		n = 0;
		do begin
			if ($urandom_range(0, 9) == 0)
				c.step = pick_step();
			send_item(c);
			n++;
		end while (!joints_settled(c) && n < lim);
	endtask

	task automatic run_motion(int n_items);
		slew_cmd_t c;
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 75) begin
				ramp_episode();
			end else begin
				// noise: unrelated single item, either opcode, any step
				c.op = $urandom_range(0, 1) ? OP_RAMP : OP_JUMP;
				for (int j = 0; j < 3; j++)
					c.tgt[j] = pick_angle();
				c.step = STEP_W'($urandom_range(0, 255));
				send_item(c);
			end
		end
	endtask

	// --- tests -----------------------------------------------------------

	// joints start at -1: targets of -1 must report stopped
	task automatic test_reset_state();
		send_move(OP_JUMP, -1, -1, -1, 0);
		send_move(OP_RAMP, -1, -1, -1, 255);
		send_move(OP_RAMP, 0, -1, 5, 1);
	endtask

	// zero step, exact landing, overshoot clamp, extremes, negative truncation
	task automatic test_directed_moves();
		send_move(OP_JUMP, 0, 180, 90, 0);
		send_move(OP_RAMP, 360, 180, 90, 0);
		send_move(OP_RAMP, 360, -180, 90, 255);
		send_move(OP_RAMP, 360, -180, 90, 255);
		send_move(OP_JUMP, -180, 360, -180, 128);
		send_move(OP_RAMP, -170, 350, -179, 10);
		send_move(OP_RAMP, -1, 1, 181, 1);
		send_move(OP_JUMP, -1, 1, 181, 7);
		send_move(OP_JUMP, -1, 1, 179, 0);
		send_move(OP_RAMP, 100, 1, 179, 64);
		send_move(OP_JUMP, 100, 1, 179, 3);
		send_move(OP_JUMP, 359, -179, 2, 170);
		send_move(OP_RAMP, -180, 360, -180, 85);
		send_move(OP_RAMP, -3, 3, -2, 255);
	endtask

	task automatic probe_angles();
		send_move(OP_JUMP, -180, 360, 0, 0);
		send_move(OP_JUMP, 0, 180, -180, 0);
		send_move(OP_JUMP, 180, -1, 360, 0);
		send_move(OP_JUMP, 360, 0, -1, 0);
		send_move(OP_RAMP, 359, 1, 1, 255);
	endtask

	task automatic test_random_motion();
		run_motion(150);
		// back-to-back stretch, no stalls on either side
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_motion(60);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		wait_until_quiet();
		run_motion(200);
	endtask

	task automatic test_range_extremes();
		apply_range(0, 4095, 0, 4095, 0, 4095);
		probe_angles();
		run_motion(45);
		apply_range(4095, 0, 4095, 0, 4095, 0);   // negative slope
		probe_angles();
		run_motion(45);
		apply_range(0, 0, 0, 0, 0, 0);
		probe_angles();
		run_motion(25);
		apply_range(4095, 4095, 4095, 4095, 4095, 4095);
		probe_angles();
		run_motion(25);
		apply_range(0, 4095, 4095, 0, 600, 150);
		probe_angles();
		run_motion(45);
	endtask

	// writes past the last register must leave the ranges alone
	task automatic test_ignored_registers();
		wait_until_quiet();
		cfg_write(REG_SPARE_LO, CFG_W'($urandom_range(0, 4095)));
		cfg_write(REG_SPARE_HI, '1);
		cfg_write(REG_SPARE_LO, '0);
		probe_angles();
		run_motion(20);
	endtask

	task automatic test_random_ranges();
		for (int k = 0; k < 3; k++) begin
			apply_range(pick_pulse(), pick_pulse(), pick_pulse(), pick_pulse(),
				pick_pulse(), pick_pulse());
			run_motion(60);
		end
	endtask

	initial begin
		for (int j = 0; j < 3; j++) begin
			joint_ang[j] = -1;
			range_lo[j]  = PULSE_MIN_RST;
			range_hi[j]  = PULSE_MAX_RST;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_directed_moves();
		test_random_motion();
		test_range_extremes();
		test_ignored_registers();
		test_random_ranges();

		wait_until_quiet();
		$display("Run covered %0d items (%0d ramp, %0d jump), %0d results checked.",
			items_sent, ramp_items, jump_items, updates_seen);
		$display("Register writes: %0d over %0d range settings; sender drained %0d times.",
			reg_writes, range_sets, quiet_waits);
		if (err_count == 0 && due_updates.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// hard stop if a handshake never completes
	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: timeout, %0d results still expected", $time, due_updates.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
